// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RTCTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never be true outside reset
`define RTCTM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: sv/rtctm_pkg.sv
// types and constants of the real-time clock with alarm
package rtctm_pkg;

    localparam int NUM_CLOCK = 12;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [3:0] REG_SEC   = 4'd0;
    localparam logic [3:0] REG_MIN   = 4'd1;
    localparam logic [3:0] REG_HOUR  = 4'd2;
    localparam logic [3:0] REG_DAY   = 4'd3;
    localparam logic [3:0] REG_SUB   = 4'd4;
    localparam logic [3:0] REG_ASEC  = 4'd5;
    localparam logic [3:0] REG_AMIN  = 4'd6;
    localparam logic [3:0] REG_AHOUR = 4'd7;
    localparam logic [3:0] REG_CTRL  = 4'd10;
    localparam logic [3:0] IDX_FLAGS = 4'd15;

    localparam logic [7:0] HOUR_MASK      = 8'h1f;
    localparam logic [7:0] MINSEC_MASK    = 8'h3f;
    localparam logic [7:0] SEC_WRAP       = 8'd60;
    localparam logic [7:0] HOUR_WRAP      = 8'd24;
    localparam logic [7:0] ALARM_CLR_MASK = 8'hfd;

    localparam int BIT_HALF_EN  = 0;
    localparam int BIT_ALARM_EN = 1;
    localparam int BIT_FIELD_EN = 7;

    typedef logic [NUM_CLOCK-1:0][7:0] t_regs;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] reg_index;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       alarm_hit;
        logic       half_second_irq;
    } t_out_item;

    typedef struct packed {
        t_regs      regs;
        logic [7:0] flags;
        logic       alarm_hit;
        logic       half_irq;
    } t_tick_res;

endpackage

// File: sv/rtc_time_counter_with_alarm_core.sv
// real-time clock with alarm: input register, one pass of logic, result register
// an input beat goes to the input register, then its result to the result register
// throughput: one beat per cycle while the result register is not stalled
// the state update and result come from the single logic stage after the input register
// reset (synchronous, active low) clears the clock registers, flags, sub-second count
// and both valid bits; the first beat can be taken the cycle after reset is released
module rtc_time_counter_with_alarm_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  rtctm_pkg::t_in_item    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output rtctm_pkg::t_out_item   o_out_data
);
    import rtctm_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out, n_out;

    t_regs      r_regs, n_regs;
    logic [7:0] r_flags, n_flags;
    logic [7:0] r_sub, n_sub;

    t_tick_res tick_res;
    logic      stall, fire, idx_clock;

    assign stall      = r_out_valid && !i_out_ready;
    assign fire       = r_in_valid && !stall;
    assign o_in_ready = !r_in_valid || fire;
    assign idx_clock  = ({1'b0, r_in.reg_index} < 5'(NUM_CLOCK));

    rtctm_tick u_tick (
        .i_regs  (r_regs),
        .i_flags (r_flags),
        .i_sub   (r_sub),
        .o_res   (tick_res)
    );

    always_comb begin
        n_regs  = r_regs;
        n_flags = r_flags;
        n_sub   = r_sub;
        n_out   = '0;
        case (r_in.mode)
            MODE_TICK: begin
                n_regs                = tick_res.regs;
                n_flags               = tick_res.flags;
                n_sub                 = r_sub + 8'd1;
                n_out.alarm_hit       = tick_res.alarm_hit;
                n_out.half_second_irq = tick_res.half_irq;
            end
            MODE_WRITE: begin
                if (idx_clock) begin
                    n_regs[r_in.reg_index] = r_in.write_data;
                end else if (r_in.reg_index == IDX_FLAGS) begin
                    n_flags = r_in.write_data;
                end
            end
            MODE_READ: begin
                if (idx_clock) begin
                    n_out.read_data = r_regs[r_in.reg_index];
                end else if (r_in.reg_index == IDX_FLAGS) begin
                    n_out.read_data = r_flags;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
            r_flags     <= '0;
            r_sub       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_regs      <= n_regs;
                r_flags     <= n_flags;
                r_sub       <= n_sub;
                r_out_valid <= 1'b1;
            end else if (!stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/rtctm_tick.sv
// next clock state, alarm match and half-second interrupt for one tick
module rtctm_tick (
    input  rtctm_pkg::t_regs     i_regs,
    input  logic [7:0]           i_flags,
    input  logic [7:0]           i_sub,
    output rtctm_pkg::t_tick_res o_res
);
    import rtctm_pkg::*;

    logic [7:0] sec_inc, min_inc, hour_inc;
    logic       sec_start, wrap_s, wrap_m, wrap_h;
    logic [7:0] sec_n, min_n, hour_n, day_n;
    logic [7:0] ahour, amin, asec, ctrl;
    logic       mis_h, mis_m, mis_s, any_en, match;

    assign sec_start = (i_sub == 8'd0);
    assign sec_inc   = i_regs[REG_SEC] + 8'd1;
    assign min_inc   = i_regs[REG_MIN] + 8'd1;
    assign hour_inc  = i_regs[REG_HOUR] + 8'd1;
    assign wrap_s    = sec_start && (sec_inc == SEC_WRAP);
    assign wrap_m    = wrap_s && (min_inc == SEC_WRAP);
    assign wrap_h    = wrap_m && (hour_inc == HOUR_WRAP);

    always_comb begin
        sec_n  = i_regs[REG_SEC];
        min_n  = i_regs[REG_MIN];
        hour_n = i_regs[REG_HOUR];
        day_n  = i_regs[REG_DAY];
        if (sec_start) begin
            sec_n = wrap_s ? 8'd0 : sec_inc;
        end
        if (wrap_s) begin
            min_n = wrap_m ? 8'd0 : min_inc;
        end
        if (wrap_m) begin
            hour_n = wrap_h ? 8'd0 : hour_inc;
        end
        if (wrap_h) begin
            day_n = i_regs[REG_DAY] + 8'd1;
        end
    end

    // alarm compares against the already advanced time
    assign ahour  = i_regs[REG_AHOUR];
    assign amin   = i_regs[REG_AMIN];
    assign asec   = i_regs[REG_ASEC];
    assign ctrl   = i_regs[REG_CTRL];
    assign mis_h  = ahour[BIT_FIELD_EN] && (((ahour ^ hour_n) & HOUR_MASK) != 8'd0);
    assign mis_m  = amin[BIT_FIELD_EN] && (((amin ^ min_n) & MINSEC_MASK) != 8'd0);
    assign mis_s  = asec[BIT_FIELD_EN] && (((asec ^ sec_n) & MINSEC_MASK) != 8'd0);
    assign any_en = ahour[BIT_FIELD_EN] || amin[BIT_FIELD_EN] || asec[BIT_FIELD_EN];
    assign match  = ctrl[BIT_ALARM_EN] && i_flags[BIT_ALARM_EN]
                    && any_en && !mis_h && !mis_m && !mis_s;

    always_comb begin
        o_res.regs           = i_regs;
        o_res.regs[REG_SEC]  = sec_n;
        o_res.regs[REG_MIN]  = min_n;
        o_res.regs[REG_HOUR] = hour_n;
        o_res.regs[REG_DAY]  = day_n;
        o_res.regs[REG_SUB]  = i_sub;
        o_res.alarm_hit      = sec_start && match;
        o_res.half_irq       = (i_sub[6:0] == 7'd0) && !o_res.alarm_hit
                               && ctrl[BIT_HALF_EN] && i_flags[BIT_HALF_EN];
        o_res.flags          = o_res.alarm_hit ? (i_flags & ALARM_CLR_MASK) : i_flags;
    end

endmodule

// File: sv/rtctm_checker.sv
// port-level checks for the clock core, bound into the core module
`include "assert_macros.svh"

module rtctm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input rtctm_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input rtctm_pkg::t_out_item o_out_data
);
    import rtctm_pkg::*;

    logic in_beat;
    logic out_stalled;
    logic both_events;
    logic read_with_event;

    assign in_beat         = i_in_valid && o_in_ready;
    assign out_stalled     = o_out_valid && !i_out_ready;
    assign both_events     = o_out_valid && o_out_data.alarm_hit
                             && o_out_data.half_second_irq;
    assign read_with_event = o_out_valid && (o_out_data.read_data != 8'd0)
                             && (o_out_data.alarm_hit || o_out_data.half_second_irq);

    // a stalled result beat holds
    `RTCTM_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, $past(out_stalled), o_out_valid && $stable(o_out_data), "stalled result beat changed")

    // a fresh result comes from an input beat through the input register and the result register
    `RTCTM_ASSERT_IMPL(a_out_from_in, i_clk, i_rst_n, $rose(o_out_valid), $past(in_beat, 2), "result with no input beat")

    // alarm hit suppresses the half-second interrupt
    `RTCTM_ASSERT_NEVER(a_evt_excl, i_clk, i_rst_n, both_events, "alarm and half-second irq together")

    // only ticks raise events and ticks read as zero
    `RTCTM_ASSERT_NEVER(a_read_no_evt, i_clk, i_rst_n, read_with_event, "read data with an event")

endmodule

bind rtc_time_counter_with_alarm_core rtctm_checker u_rtctm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: bench/tb_top.sv
// self-checking testbench for the real-time clock with alarm core
`timescale 1ns / 1ps

module tb_top;
    import rtctm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_LEN     = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTS   = 50;

    localparam logic [1:0] MODE_NONE    = 2'd3;
    localparam logic [3:0] IDX_SPARE_LO = 4'd12;
    localparam logic [3:0] IDX_SPARE_HI = 4'd14;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // predicted clock state
    logic [7:0] time_regs [NUM_CLOCK] = '{default: 8'h00};
    logic [7:0] int_flags = 8'h00;
    logic [7:0] sub_count = 8'h00;

    t_in_item  rtc_items_todo[$];
    t_out_item rtc_results_due[$];

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_req       = 0;
    int         hold_seen      = 0;
    int         hold_left      = 0;
    logic       in_beat_taken  = 1'b0;
    int         idle_cycles    = 0;
    int         err_count      = 0;
    logic [7:0] gen_sub        = 8'h00;

    rtc_time_counter_with_alarm_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_out_item next_rtc_result(t_in_item it);
        t_out_item res;
        logic      match;
        logic      any_field;
        res = '0;
        case (it.mode)
            MODE_TICK: begin
                if (sub_count == 8'h00) begin
                    time_regs[REG_SEC] = time_regs[REG_SEC] + 8'd1;
                    if (time_regs[REG_SEC] == SEC_WRAP) begin
                        time_regs[REG_SEC] = 8'h00;
                        time_regs[REG_MIN] = time_regs[REG_MIN] + 8'd1;
                        if (time_regs[REG_MIN] == SEC_WRAP) begin
                            time_regs[REG_MIN]  = 8'h00;
                            time_regs[REG_HOUR] = time_regs[REG_HOUR] + 8'd1;
                            if (time_regs[REG_HOUR] == HOUR_WRAP) begin
                                time_regs[REG_HOUR] = 8'h00;
                                time_regs[REG_DAY]  = time_regs[REG_DAY] + 8'd1;
                            end
                        end
                    end
                end
                time_regs[REG_SUB] = sub_count;
                // every enabled alarm field must match, and at least one must be enabled
                match     = time_regs[REG_CTRL][BIT_ALARM_EN] && int_flags[BIT_ALARM_EN];
                any_field = 1'b0;
                if (time_regs[REG_AHOUR][BIT_FIELD_EN]) begin
                    any_field = 1'b1;
                    if (((time_regs[REG_AHOUR] ^ time_regs[REG_HOUR]) & HOUR_MASK) != 8'h00)
                        match = 1'b0;
                end
                if (time_regs[REG_AMIN][BIT_FIELD_EN]) begin
                    any_field = 1'b1;
                    if (((time_regs[REG_AMIN] ^ time_regs[REG_MIN]) & MINSEC_MASK) != 8'h00)
                        match = 1'b0;
                end
                if (time_regs[REG_ASEC][BIT_FIELD_EN]) begin
                    any_field = 1'b1;
                    if (((time_regs[REG_ASEC] ^ time_regs[REG_SEC]) & MINSEC_MASK) != 8'h00)
                        match = 1'b0;
                end
                if (sub_count[6:0] == 7'd0) begin
                    if (sub_count == 8'h00 && match && any_field) begin
                        res.alarm_hit = 1'b1;
                        int_flags     = int_flags & ALARM_CLR_MASK;
                    end else if (time_regs[REG_CTRL][BIT_HALF_EN] && int_flags[BIT_HALF_EN]) begin
                        res.half_second_irq = 1'b1;
                    end
                end
                sub_count = sub_count + 8'd1;
            end
            MODE_WRITE: begin
                if (it.reg_index < NUM_CLOCK)
                    time_regs[it.reg_index] = it.write_data;
                else if (it.reg_index == IDX_FLAGS)
                    int_flags = it.write_data;
            end
            MODE_READ: begin
                if (it.reg_index < NUM_CLOCK)
                    res.read_data = time_regs[it.reg_index];
                else if (it.reg_index == IDX_FLAGS)
                    res.read_data = int_flags;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_item(input logic [1:0] mode, input logic [3:0] idx,
                             input logic [7:0] data);
        t_in_item it;
        it.mode       = mode;
        it.reg_index  = idx;
        it.write_data = data;
        rtc_items_todo.push_back(it);
        if (mode == MODE_TICK)
            gen_sub = gen_sub + 8'd1;
    endtask

    task automatic gen_traffic(input int n);
        logic [3:0] alarm_idx  [3];
        logic [7:0] alarm_mask [3];
        logic [7:0] post       [3];
        logic [7:0] sec_v;
        logic [7:0] min_v;
        logic [7:0] hour_v;
        logic [7:0] aval;
        int         pick;
        int         k;
        int         f;
        alarm_idx  = '{REG_ASEC, REG_AMIN, REG_AHOUR};
        alarm_mask = '{MINSEC_MASK, MINSEC_MASK, HOUR_MASK};
        for (k = 0; k < n; k++) begin
            if (gen_sub == 8'd0) begin
                // next tick rolls the second: arm an alarm that hits or just misses
                pick = $urandom_range(3);
                if (pick == 0) begin
                    sec_v  = SEC_WRAP - 8'd1;
                    min_v  = SEC_WRAP - 8'd1;
                    hour_v = HOUR_WRAP - 8'd1;
                    post   = '{8'd0, 8'd0, 8'd0};
                    push_item(MODE_WRITE, REG_DAY,
                              ($urandom_range(1) != 0) ? 8'hff : 8'($urandom_range(255)));
                end else begin
                    // out-of-range seconds just count on
                    sec_v  = (pick == 1) ? 8'($urandom_range(255, 60)) : 8'($urandom_range(58));
                    min_v  = 8'($urandom_range(59));
                    hour_v = 8'($urandom_range(23));
                    post   = '{sec_v + 8'd1, min_v, hour_v};
                end
                push_item(MODE_WRITE, REG_SEC, sec_v);
                push_item(MODE_WRITE, REG_MIN, min_v);
                push_item(MODE_WRITE, REG_HOUR, hour_v);
                for (f = 0; f < 3; f++) begin
                    aval = (post[f] & alarm_mask[f]) | (8'($urandom_range(127)) & ~alarm_mask[f]);
                    if ($urandom_range(1) != 0)
                        aval[BIT_FIELD_EN] = 1'b1;
                    if ($urandom_range(4) == 0)
                        aval = aval ^ (8'h01 << $urandom_range(4));
                    push_item(MODE_WRITE, alarm_idx[f], aval);
                end
                aval = 8'($urandom_range(255));
                aval[BIT_ALARM_EN] = ($urandom_range(5) != 0);
                push_item(MODE_WRITE, REG_CTRL, aval);
                aval = 8'($urandom_range(255));
                aval[BIT_ALARM_EN] = ($urandom_range(5) != 0);
                push_item(MODE_WRITE, IDX_FLAGS, aval);
                push_item(MODE_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
                push_item(MODE_READ, IDX_FLAGS, 8'($urandom_range(255)));
            end else if (gen_sub == 8'd128) begin
                // half-second point
                aval = 8'($urandom_range(255));
                aval[BIT_HALF_EN] = ($urandom_range(3) != 0);
                push_item(MODE_WRITE, REG_CTRL, aval);
                aval = 8'($urandom_range(255));
                aval[BIT_HALF_EN] = ($urandom_range(3) != 0);
                push_item(MODE_WRITE, IDX_FLAGS, aval);
                push_item(MODE_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 85)
                    push_item(MODE_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
                else if (pick < 92)
                    push_item(MODE_WRITE, 4'($urandom_range(15)), 8'($urandom_range(255)));
                else if (pick < 99)
                    push_item(MODE_READ, 4'($urandom_range(15)), 8'($urandom_range(255)));
                else
                    push_item(MODE_NONE, 4'($urandom_range(15)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic drain_results();
        do
            @(posedge i_clk);
        while (rtc_items_todo.size() != 0 || i_in_valid || rtc_results_due.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (err_count < MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // driver: next beat goes out once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beat_taken)) begin
            if (rtc_items_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= rtc_items_todo.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge i_clk) begin
        t_out_item want;
        in_beat_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_beat_taken = 1'b1;
                rtc_results_due.push_back(next_rtc_result(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (rtc_results_due.size() == 0) begin
                    flag_mismatch("unexpected beat", o_out_data.read_data, 8'h00);
                end else begin
                    want = rtc_results_due.pop_front();
                    if (o_out_data.read_data !== want.read_data)
                        flag_mismatch("read_data", o_out_data.read_data, want.read_data);
                    if (o_out_data.alarm_hit !== want.alarm_hit)
                        flag_mismatch("alarm_hit", o_out_data.alarm_hit, want.alarm_hit);
                    if (o_out_data.half_second_irq !== want.half_second_irq)
                        flag_mismatch("half_second_irq", o_out_data.half_second_irq,
                                      want.half_second_irq);
                end
            end
            if (in_beat_taken || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, unused indexes and the unused mode
        push_item(MODE_READ, IDX_FLAGS, 8'h00);
        push_item(MODE_READ, REG_SEC, 8'h00);
        push_item(MODE_WRITE, IDX_SPARE_LO, 8'hff);
        push_item(MODE_READ, IDX_SPARE_LO, 8'h00);
        push_item(MODE_WRITE, IDX_SPARE_HI, 8'h5a);
        push_item(MODE_READ, IDX_SPARE_HI, 8'hff);
        push_item(MODE_NONE, IDX_FLAGS, 8'hff);
        // full rollover into the day wrap, with an alarm at midnight
        push_item(MODE_WRITE, REG_SEC, SEC_WRAP - 8'd1);
        push_item(MODE_WRITE, REG_MIN, SEC_WRAP - 8'd1);
        push_item(MODE_WRITE, REG_HOUR, HOUR_WRAP - 8'd1);
        push_item(MODE_WRITE, REG_DAY, 8'hff);
        push_item(MODE_WRITE, REG_ASEC, 8'h80);
        push_item(MODE_WRITE, REG_AMIN, 8'hc0);
        push_item(MODE_WRITE, REG_AHOUR, 8'he0);
        push_item(MODE_WRITE, REG_CTRL, 8'hff);
        push_item(MODE_WRITE, IDX_FLAGS, 8'hff);
        push_item(MODE_TICK, IDX_FLAGS, 8'hff);
        push_item(MODE_READ, REG_SEC, 8'h00);
        push_item(MODE_READ, REG_MIN, 8'h00);
        push_item(MODE_READ, REG_HOUR, 8'h00);
        push_item(MODE_READ, REG_DAY, 8'h00);
        push_item(MODE_READ, REG_SUB, 8'h00);
        push_item(MODE_READ, IDX_FLAGS, 8'h00);
        gen_traffic(240);
        drain_results();

        // long output hold-off while the sender keeps pushing
        hold_req++;
        gen_traffic(30);
        drain_results();

        send_idle_pct = 81;
        gen_traffic(240);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 81;
        gen_traffic(240);
        drain_results();

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        gen_traffic(200);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
